// ===== src/iwg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwg_pkg
// Shared types and constants for the im2col window gather block.
// ----------------------------------------------------------------------------
package iwg_pkg;

	localparam int SIDE_BITS = 6;
	localparam int ADDR_BITS = 2 * SIDE_BITS;
	localparam int MROW_BITS = 12;
	localparam int MCOL_BITS = 14;
	localparam int DIM_BITS  = 7;
	localparam int KER_BITS  = 3;
	localparam int CHN_BITS  = 9;
	localparam int CHAN_BITS = 8;
	localparam int TAP_BITS  = 6;
	localparam int CIDX_BITS = 3;

	localparam logic [DIM_BITS-1:0] MAX_SIDE = DIM_BITS'(1 << SIDE_BITS);

	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_EMIT  = 1'b1;

	localparam logic [CIDX_BITS-1:0] CFG_IMAGE_HEIGHT  = 3'd0;
	localparam logic [CIDX_BITS-1:0] CFG_IMAGE_WIDTH   = 3'd1;
	localparam logic [CIDX_BITS-1:0] CFG_KERNEL_HEIGHT = 3'd2;
	localparam logic [CIDX_BITS-1:0] CFG_KERNEL_WIDTH  = 3'd3;
	localparam logic [CIDX_BITS-1:0] CFG_CHANNEL_COUNT = 3'd4;

	typedef struct packed {
		logic [DIM_BITS-1:0] height;
		logic [DIM_BITS-1:0] width;
		logic [KER_BITS-1:0] kh;
		logic [KER_BITS-1:0] kw;
		logic [CHN_BITS-1:0] chans;
	} cfg_t;

	typedef struct packed {
		logic                 err;
		logic                 pad;
		logic                 last;
		logic [ADDR_BITS-1:0] addr;
		logic [MROW_BITS-1:0] mrow;
		logic [MCOL_BITS-1:0] mcol;
	} tap_t;

endpackage

// ===== src/iwg_madd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwg_madd
// Shared multiply-add unit with a registered result: p = a * b + c.
// ----------------------------------------------------------------------------
module iwg_madd (
	input  logic        clk,
	input  logic [7:0]  a,
	input  logic [6:0]  b,
	input  logic [5:0]  c,
	output logic [14:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= 15'(a * b) + {9'b0, c};
	end

endmodule

// ===== src/iwg_plane_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwg_plane_mem
// Plane store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module iwg_plane_mem #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [iwg_pkg::ADDR_BITS-1:0] waddr,
	input  logic [DATA_WIDTH-1:0]    wdata,
	input  logic                     re,
	input  logic [iwg_pkg::ADDR_BITS-1:0] raddr,
	output logic [DATA_WIDTH-1:0]    rdata_q
);
	import iwg_pkg::*;

	logic [DATA_WIDTH-1:0] mem [1 << ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data while the consumer stalls
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

// ===== src/iwg_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwg_seq
// Emit sequencer: runs the setup products through the shared multiply-add
// unit, then walks the kernel window one tap per request taken.
// ----------------------------------------------------------------------------
module iwg_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  iwg_pkg::cfg_t                 cfg,
	input  logic                          start,
	input  logic [iwg_pkg::SIDE_BITS-1:0] row,
	input  logic [iwg_pkg::SIDE_BITS-1:0] col,
	input  logic [iwg_pkg::CHAN_BITS-1:0] channel,
	output logic                          busy,
	output logic                          tap_valid,
	output iwg_pkg::tap_t                 tap,
	input  logic                          take
);
	import iwg_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_AREA   = 7'b0000010,
		S_BASE   = 7'b0000100,
		S_ROW    = 7'b0001000,
		S_LAUNCH = 7'b0010000,
		S_RUN    = 7'b0100000,
		S_ERR    = 7'b1000000
	} state_t;

	state_t                state_q;
	logic [SIDE_BITS-1:0]  row_q;
	logic [SIDE_BITS-1:0]  col_q;
	logic [CHAN_BITS-1:0]  chan_q;
	logic [MCOL_BITS-1:0]  base_q;
	logic [MROW_BITS-1:0]  mrow_q;
	logic [KER_BITS-1:0]   i_q;
	logic [KER_BITS-1:0]   j_q;
	logic [TAP_BITS-1:0]   tap_q;

	logic [7:0]            ma;
	logic [6:0]            mb;
	logic [5:0]            mc;
	logic [14:0]           prod;
	logic                  bad;
	logic [KER_BITS-2:0]   hr;
	logic [KER_BITS-2:0]   hc;
	logic [DIM_BITS-1:0]   trb;
	logic [DIM_BITS-1:0]   tcb;
	logic [DIM_BITS-1:0]   tr;
	logic [DIM_BITS-1:0]   tc;
	logic                  in_r;
	logic                  in_c;
	logic                  last_tap;

	iwg_madd u_madd (
		.clk (clk),
		.a   (ma),
		.b   (mb),
		.c   (mc),
		.p_q (prod)
	);

	always_comb begin
		ma = {5'b0, cfg.kh};
		mb = {4'b0, cfg.kw};
		mc = '0;
		case (state_q)
			S_BASE: begin
				ma = chan_q;
				mb = {1'b0, prod[5:0]};
			end
			S_ROW: begin
				ma = {2'b0, row_q};
				mb = cfg.width;
				mc = col_q;
			end
			default: begin
			end
		endcase
	end

	assign bad = !cfg.kh[0] || !cfg.kw[0] ||
		cfg.height == '0 || cfg.height > MAX_SIDE ||
		cfg.width == '0 || cfg.width > MAX_SIDE ||
		{1'b0, row} >= cfg.height || {1'b0, col} >= cfg.width ||
		{1'b0, channel} >= cfg.chans;

	// taps are offset by the half kernel so the sums stay unsigned
	assign hr       = cfg.kh[KER_BITS-1:1];
	assign hc       = cfg.kw[KER_BITS-1:1];
	assign trb      = {1'b0, row_q} + {4'b0, i_q};
	assign tcb      = {1'b0, col_q} + {4'b0, j_q};
	assign tr       = trb - {5'b0, hr};
	assign tc       = tcb - {5'b0, hc};
	assign in_r     = trb >= {5'b0, hr} && tr < cfg.height;
	assign in_c     = tcb >= {5'b0, hc} && tc < cfg.width;
	assign last_tap = i_q == cfg.kh - 3'd1 && j_q == cfg.kw - 3'd1;

	assign busy      = state_q != S_IDLE;
	assign tap_valid = state_q == S_RUN || state_q == S_ERR;

	always_comb begin
		tap = '0;
		if (state_q == S_ERR) begin
			tap.err  = 1'b1;
			tap.last = 1'b1;
		end else begin
			tap.pad  = !(in_r && in_c);
			tap.last = last_tap;
			tap.addr = {tr[SIDE_BITS-1:0], tc[SIDE_BITS-1:0]};
			tap.mrow = mrow_q;
			tap.mcol = base_q + {8'b0, tap_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (start) state_q <= bad ? S_ERR : S_AREA;
				S_AREA:   state_q <= S_BASE;
				S_BASE:   state_q <= S_ROW;
				S_ROW:    state_q <= S_LAUNCH;
				S_LAUNCH: state_q <= S_RUN;
				S_RUN:    if (take && last_tap) state_q <= S_IDLE;
				S_ERR:    if (take) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			row_q  <= row;
			col_q  <= col;
			chan_q <= channel;
			i_q    <= '0;
			j_q    <= '0;
			tap_q  <= '0;
		end
		if (state_q == S_ROW) begin
			base_q <= prod[MCOL_BITS-1:0];
		end
		if (state_q == S_LAUNCH) begin
			mrow_q <= prod[MROW_BITS-1:0];
		end
		// advance kernel column, wrap into the next kernel row
		if (state_q == S_RUN && take) begin
			tap_q <= tap_q + 6'd1;
			if (j_q == cfg.kw - 3'd1) begin
				j_q <= '0;
				i_q <= i_q + 3'd1;
			end else begin
				j_q <= j_q + 3'd1;
			end
		end
	end

endmodule

// ===== src/im2col_window_gather.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// im2col_window_gather
// im2col gather with zero padding and stride 1 over one image channel plane.
// ----------------------------------------------------------------------------
// A store request writes one pixel into the 64 x 64 plane memory. An emit
// request first computes the kernel area, column base and matrix row through
// one shared multiply-add unit, then issues one tap per cycle from the single
// read port of the plane memory while the output is not stalled, and holds
// the input off until its last tap is taken; a rejected emit gives one error
// result and holds the input off until that result is taken.
// Plane entries hold no defined value until a store has written them.
// Configuration writes are taken at any time but must only be issued while
// no request is in flight.
// ----------------------------------------------------------------------------
module im2col_window_gather #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [iwg_pkg::CIDX_BITS-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [iwg_pkg::SIDE_BITS-1:0] row,
	input  logic [iwg_pkg::SIDE_BITS-1:0] col,
	input  logic [iwg_pkg::CHAN_BITS-1:0] channel,
	input  logic [DATA_WIDTH-1:0]         pixel_value,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [DATA_WIDTH-1:0]         element_value,
	output logic [iwg_pkg::MROW_BITS-1:0] matrix_row,
	output logic [iwg_pkg::MCOL_BITS-1:0] matrix_col,
	output logic                          padded,
	output logic                          error,
	output logic                          last
);
	import iwg_pkg::*;

	cfg_t                  cfg_q;
	logic                  in_acc;
	logic                  start;
	logic                  store_we;
	logic                  busy;
	logic                  tap_valid;
	tap_t                  tap;
	logic                  take;
	logic                  adv_out;
	logic                  s1_valid_q;
	tap_t                  tap_s1;
	logic [DATA_WIDTH-1:0] rdata;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] elem_q;
	logic [MROW_BITS-1:0]  mrow_q;
	logic [MCOL_BITS-1:0]  mcol_q;
	logic                  pad_q;
	logic                  err_q;
	logic                  last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.height <= DIM_BITS'(1);
			cfg_q.width  <= DIM_BITS'(1);
			cfg_q.kh     <= KER_BITS'(1);
			cfg_q.kw     <= KER_BITS'(1);
			cfg_q.chans  <= CHN_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_HEIGHT:  cfg_q.height <= cfg_data[DIM_BITS-1:0];
				CFG_IMAGE_WIDTH:   cfg_q.width  <= cfg_data[DIM_BITS-1:0];
				CFG_KERNEL_HEIGHT: cfg_q.kh     <= cfg_data[KER_BITS-1:0];
				CFG_KERNEL_WIDTH:  cfg_q.kw     <= cfg_data[KER_BITS-1:0];
				CFG_CHANNEL_COUNT: cfg_q.chans  <= cfg_data[CHN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_ready = !busy;
	assign in_acc   = in_valid && in_ready;
	assign start    = in_acc && command == CMD_EMIT;
	// drop stores outside the plane
	assign store_we = in_acc && command == CMD_STORE &&
		cfg_q.height != '0 && cfg_q.height <= MAX_SIDE &&
		cfg_q.width != '0 && cfg_q.width <= MAX_SIDE &&
		{1'b0, row} < cfg_q.height && {1'b0, col} < cfg_q.width;

	iwg_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (start),
		.row       (row),
		.col       (col),
		.channel   (channel),
		.busy      (busy),
		.tap_valid (tap_valid),
		.tap       (tap),
		.take      (take)
	);

	assign adv_out = !out_valid_q || out_ready;
	assign take    = tap_valid && (!s1_valid_q || adv_out);

	iwg_plane_mem #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_mem (
		.clk     (clk),
		.we      (store_we),
		.waddr   ({row, col}),
		.wdata   (pixel_value),
		.re      (take),
		.raddr   (tap.addr),
		.rdata_q (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				s1_valid_q <= 1'b1;
			end else if (adv_out) begin
				s1_valid_q <= 1'b0;
			end
			if (adv_out) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tap_s1 <= tap;
		end
		if (adv_out && s1_valid_q) begin
			elem_q <= (tap_s1.pad || tap_s1.err) ? '0 : rdata;
			mrow_q <= tap_s1.mrow;
			mcol_q <= tap_s1.mcol;
			pad_q  <= tap_s1.pad;
			err_q  <= tap_s1.err;
			last_q <= tap_s1.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign element_value = elem_q;
	assign matrix_row    = mrow_q;
	assign matrix_col    = mcol_q;
	assign padded        = pad_q;
	assign error         = err_q;
	assign last          = last_q;

`ifndef NO_ASSERTIONS
	a_busy_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !in_ready)
		else $error("input taken during emit sequence");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last && !padded && matrix_row == '0 && matrix_col == '0)
		else $error("error result not a lone zeroed result");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && padded |-> element_value == '0)
		else $error("padded tap carries nonzero data");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !adv_out |=> s1_valid_q && $stable(tap_s1))
		else $error("stalled tap stage lost its request");
`endif

endmodule
